### rtl/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manchester receiver package
// Shared widths, reset values and the result record of the edge-timed
// Manchester receiver.
// ----------------------------------------------------------------------------
package mer_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int WORD_BITS     = 8;
   localparam int CFG_WIDTH     = 16;
   localparam int BYTE_WIDTH    = 8;
   localparam int BIT_CNT_WIDTH = $clog2(WORD_BITS + 1);
   localparam int CMP_WIDTH     = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   localparam logic [CFG_WIDTH-1:0] MIN_TICKS_RESET = CFG_WIDTH'(79);

   // Kinds of request carried on the input sideband.
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_EDGE = 1'b1;

   typedef struct packed {
      logic                  byte_ready;
      logic [BYTE_WIDTH-1:0] byte_value;
      logic                  receiving;
   } mer_result_type;

endpackage

### rtl/mer_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manchester receiver decoder
// Holds the receive state and works out the result of one request in a
// single pass; the state advances only when a request is accepted.
// ----------------------------------------------------------------------------
module mer_decoder
   import mer_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 action,
   input  logic                 line_level,
   input  logic [CFG_WIDTH-1:0] min_ticks,
   output mer_result_type       result
);

   logic                     await_start_ff, await_start_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [WORD_BITS-1:0]     shift_ff, shift_in;
   logic [BIT_CNT_WIDTH-1:0] bits_ff, bits_in;

   logic [WORD_BITS:0]            shift_wide;
   logic [WORD_BITS-1:0]          shift_next;
   logic [WORD_BITS+BYTE_WIDTH-1:0] shift_ext;
   logic [BIT_CNT_WIDTH-1:0]      bits_next;
   logic                          long_enough;
   logic                          word_done;

   assign shift_wide  = {shift_ff, ~line_level};
   assign shift_next  = shift_wide[WORD_BITS-1:0];
   assign shift_ext   = {{BYTE_WIDTH{1'b0}}, shift_next};
   assign bits_next   = bits_ff + BIT_CNT_WIDTH'(1);
   assign word_done   = (bits_next >= BIT_CNT_WIDTH'(WORD_BITS));
   assign long_enough = (CMP_WIDTH'(count_ff) >= CMP_WIDTH'(min_ticks));

   always_comb begin
      await_start_in    = await_start_ff;
      count_in          = count_ff;
      shift_in          = shift_ff;
      bits_in           = bits_ff;
      result.byte_ready = 1'b0;
      result.byte_value = '0;
      if (action == ACTION_TICK) begin
         if (count_ff != {COUNT_WIDTH{1'b1}}) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
      end else if (await_start_ff) begin
         if (!line_level) begin
            await_start_in = 1'b0;
            count_in       = '0;
         end
      end else if (long_enough) begin
         // A bit edge: falling gives a one, rising a zero.
         count_in = '0;
         if (word_done) begin
            result.byte_ready = 1'b1;
            result.byte_value = shift_ext[BYTE_WIDTH-1:0];
            shift_in          = '0;
            bits_in           = '0;
            await_start_in    = 1'b1;
         end else begin
            shift_in = shift_next;
            bits_in  = bits_next;
         end
      end
      result.receiving = ~await_start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_start_ff <= 1'b1;
         count_ff       <= '0;
         shift_ff       <= '0;
         bits_ff        <= '0;
      end else if (step_en) begin
         await_start_ff <= await_start_in;
         count_ff       <= count_in;
         shift_ff       <= shift_in;
         bits_ff        <= bits_in;
      end
   end

endmodule

### rtl/mer_rsp_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manchester receiver response register
// Holds one finished response until the downstream side takes it, and
// takes a new one in the same cycle as the old one leaves.
// ----------------------------------------------------------------------------
module mer_rsp_reg
   import mer_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  mer_result_type load_data,
   input  logic           take,
   output logic           can_load,
   output logic           valid,
   output mer_result_type data
);

   logic           valid_ff, valid_in;
   mer_result_type data_ff;

   assign can_load = ~valid_ff | take;
   assign valid_in = load | (valid_ff & ~take);
   assign valid    = valid_ff;
   assign data     = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

### rtl/manchester_edge_timed_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-timed Manchester receiver core
// Decodes Manchester bytes from a stream of timer ticks and line edges.
// ----------------------------------------------------------------------------
// Each request is a timer tick or a line edge; every request gives exactly one
// response, in the cycle after it is accepted, and a new request can be
// taken in every cycle as long as the response side keeps up. The whole step
// is one pass of logic from the receive state into the response register; a
// new request is taken in the same cycle as the last response leaves, and is
// held off for as long as that response waits. An edge counts as a bit only
// once the tick count since the last counted edge has reached the
// minimum-interval register; a falling edge starts a byte, which arrives MSB
// first and is reported with byte_ready set when complete.
module manchester_edge_timed_receiver_core
   import mer_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Requests
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [0] line_level, [7:1] zero
   input  logic                 req_tuser,  // [0] action
   // Responses
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // [7:0] byte_value, [8] receiving
   output logic                 rsp_tuser,  // [0] byte_ready
   // Minimum bit interval register
   input  logic                 csr_tvalid,
   output logic                 csr_tready,
   input  logic [CFG_WIDTH-1:0] csr_tdata
);

   logic [CFG_WIDTH-1:0] min_ticks_ff;
   logic                 req_accept;
   logic                 can_load;
   mer_result_type       step_result;
   mer_result_type       rsp_data;

   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ticks_ff <= MIN_TICKS_RESET;
      end else if (csr_tvalid) begin
         min_ticks_ff <= csr_tdata;
      end
   end

   assign req_tready = can_load;
   assign req_accept = req_tvalid & req_tready;

   mer_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_accept),
      .action     (req_tuser),
      .line_level (req_tdata[0]),
      .min_ticks  (min_ticks_ff),
      .result     (step_result)
   );

   mer_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_data (step_result),
      .take      (rsp_tready),
      .can_load  (can_load),
      .valid     (rsp_tvalid),
      .data      (rsp_data)
   );

   assign rsp_tuser = rsp_data.byte_ready;
   assign rsp_tdata = {7'b0, rsp_data.receiving, rsp_data.byte_value};

   // Every accepted request leaves a response behind it.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // A completed byte always ends reception.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tdata[8])
      else $error("receiving still set on a completed byte");

   // The byte field is clear unless a byte was completed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("byte value set without byte_ready");

   // A held response blocks further requests.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");

endmodule
